// ===== hw/rtl/rou_pkg.sv =====
// ----------------------------------------------------------------------------
// rou_pkg
// Types, constants and binary32 helper functions for the rank-one update
// element.
// ----------------------------------------------------------------------------
`default_nettype none

package rou_pkg;

    localparam int CFG_IDX_W = 1;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ALPHA = 1'b0,
        REG_SPLIT = 1'b1
    } t_reg;

    localparam logic [31:0] QNAN_BITS = 32'h7FC0_0000;
    localparam logic [30:0] INF_MAG   = 31'h7F80_0000;

    // signed exponent of m * 2^e, wide enough for every intermediate
    typedef logic signed [11:0] t_exp;

    // result of the alignment step of rounding
    typedef struct packed {
        logic [23:0] q;
        logic        g;
        logic        st;
        t_exp        lsb;
    } t_shr;

    function automatic logic f_is_nan(input logic [31:0] v);
        return (v[30:23] == 8'hFF) && (v[22:0] != 23'd0);
    endfunction

    function automatic logic f_is_inf(input logic [31:0] v);
        return v[30:0] == INF_MAG;
    endfunction

    function automatic logic f_is_zero(input logic [31:0] v);
        return v[30:0] == 31'd0;
    endfunction

    function automatic logic [23:0] f_unp_m(input logic [31:0] v);
        return (v[30:23] == 8'd0) ? {1'b0, v[22:0]} : {1'b1, v[22:0]};
    endfunction

    function automatic t_exp f_unp_e(input logic [31:0] v);
        t_exp e;
        if (v[30:23] == 8'd0) begin
            e = t_exp'(-149);
        end else begin
            e = t_exp'({4'b0000, v[30:23]}) - t_exp'(150);
        end
        return e;
    endfunction

    // index of the highest set bit, 0 for zero
    function automatic logic [5:0] f_msb(input logic [63:0] m);
        logic [5:0] k;
        k = 6'd0;
        for (int i = 0; i < 64; i++) begin
            if (m[i]) begin
                k = 6'(i);
            end
        end
        return k;
    endfunction

    // pick the binary32 lsb position and shift the mantissa onto it
    function automatic t_shr f_align(input logic [63:0] m, input t_exp e,
                                     input logic [5:0] k);
        t_shr        r;
        t_exp        lsb;
        t_exp        sh;
        t_exp        nsh;
        logic [63:0] tmp;
        logic [63:0] mask;
        logic [5:0]  s6;
        lsb = t_exp'({6'b000000, k}) + e - t_exp'(23);
        if (lsb < t_exp'(-149)) begin
            lsb = t_exp'(-149);
        end
        sh    = lsb - e;
        nsh   = -sh;
        r.lsb = lsb;
        r.q   = 24'd0;
        r.g   = 1'b0;
        r.st  = 1'b0;
        if (sh <= t_exp'(0)) begin
            s6  = nsh[5:0];
            tmp = m << s6;
            r.q = tmp[23:0];
        end else if (sh < t_exp'(64)) begin
            s6   = sh[5:0];
            tmp  = m >> s6;
            r.q  = tmp[23:0];
            r.g  = m[s6 - 6'd1];
            mask = (64'd1 << (s6 - 6'd1)) - 64'd1;
            r.st = |(m & mask);
        end
        return r;
    endfunction

    // round to nearest even and pack, overflow goes to infinity
    function automatic logic [31:0] f_pack(input logic s, input t_shr r);
        logic [24:0] qq;
        logic        inc;
        t_exp        lsb;
        t_exp        be;
        logic [31:0] res;
        inc = r.g & (r.st | r.q[0]);
        qq  = {1'b0, r.q} + 25'(inc);
        lsb = r.lsb;
        if (qq[24]) begin
            qq  = qq >> 1;
            lsb = lsb + t_exp'(1);
        end
        if (qq[23]) begin
            be = lsb + t_exp'(150);
            if (be >= t_exp'(255)) begin
                res = {s, INF_MAG};
            end else begin
                res = {s, be[7:0], qq[22:0]};
            end
        end else begin
            res = {s, 8'd0, qq[22:0]};
        end
        return res;
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/rank_one_update_element_top.sv =====
// ----------------------------------------------------------------------------
// rank_one_update_element_top
// Streaming binary32 a + (alpha*y)*x with fused or split rounding.
// ----------------------------------------------------------------------------
// Throughput: one item per cycle while i_stall is low; each of the 16 stages holds one item.
// Stages stall one by one from the output back, so bubbles are squeezed out.
// Reset (synchronous, i_rst_n low) clears all stage valids, alpha and the
// split mode; data registers are not reset.
`default_nettype none

module rank_one_update_element_top
    import rou_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // input items
    input  logic                 i_valid,
    output logic                 o_stall,
    input  logic [31:0]          i_x_value,
    input  logic [31:0]          i_y_value,
    input  logic [31:0]          i_a_value,
    // result items
    output logic                 o_valid,
    input  logic                 i_stall,
    output logic [31:0]          o_a_updated,
    // configuration writes
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [31:0]          i_cfg_data
);

    localparam int NS = 16;

    // carried alongside the first half: bypass, mode and the addend
    typedef struct packed {
        logic        byp;
        logic        split;
        logic [31:0] a;
    } t_car;

    // carried alongside the second half: final value decided early
    typedef struct packed {
        logic        spec;
        logic [31:0] val;
    } t_side;

    // ------------------------------------------------------------------
    // configuration registers, always ready
    // ------------------------------------------------------------------
    logic [31:0] r_alpha;
    logic        r_split;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_alpha <= 32'd0;
            r_split <= 1'b0;
        end else if (i_cfg_valid) begin
            unique case (t_reg'(i_cfg_index))
                REG_ALPHA: r_alpha <= i_cfg_data;
                REG_SPLIT: r_split <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // stage enables: a stage moves when empty or when the next one moves
    // ------------------------------------------------------------------
    logic [NS:1] r_vld;
    logic [NS:1] en;

    always_comb begin
        en[NS] = !r_vld[NS] || !i_stall;
        for (int i = NS - 1; i >= 1; i--) begin
            en[i] = !r_vld[i] || en[i+1];
        end
    end

    assign o_stall = !en[1];
    assign o_valid = r_vld[NS];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (en[1]) begin
                r_vld[1] <= i_valid;
            end
            for (int i = 2; i <= NS; i++) begin
                if (en[i]) begin
                    r_vld[i] <= r_vld[i-1];
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // data path registers
    // ------------------------------------------------------------------
    t_car        r_car [1:8];
    t_side       r_sd  [9:15];

    // temp = round(alpha * y)
    logic [47:0] r_s1_mp, r_s2_mp;
    t_exp        r_s1_ep, r_s2_ep;
    logic        r_s1_nan, r_s2_nan, r_s3_nan;
    logic        r_s1_inf, r_s2_inf, r_s3_inf;
    logic        r_s1_sgn, r_s2_sgn, r_s3_sgn;
    logic [31:0] r_s1_x, r_s2_x, r_s3_x, r_s4_x;
    logic [5:0]  r_s2_k;
    t_shr        r_s3_shr;
    logic [31:0] r_s4_t;

    // product x * temp, exact and (split mode) rounded
    logic [47:0] r_s5_mp, r_s6_mp, r_s7_mp, r_s8_mp;
    t_exp        r_s5_ep, r_s6_ep, r_s7_ep, r_s8_ep;
    logic        r_s5_nan, r_s6_nan, r_s7_nan, r_s8_nan;
    logic        r_s5_inf, r_s6_inf, r_s7_inf, r_s8_inf;
    logic        r_s5_zer, r_s6_zer, r_s7_zer, r_s8_zer;
    logic        r_s5_sgn, r_s6_sgn, r_s7_sgn, r_s8_sgn;
    logic [5:0]  r_s6_k;
    t_shr        r_s7_shr;
    logic [31:0] r_s8_p;

    // addition with a
    logic [47:0] r_s9_mp;
    t_exp        r_s9_ep;
    logic        r_s9_sp;
    logic [23:0] r_s9_mc;
    t_exp        r_s9_ec;
    logic        r_s9_sa, r_s9_az;
    logic [5:0]  r_s9_kp, r_s9_kc;

    logic [63:0] r_s10_np, r_s10_nc;
    t_exp        r_s10_ep, r_s10_ec;
    logic        r_s10_sp, r_s10_sa, r_s10_az;

    logic [63:0] r_s11_big, r_s11_sml;
    t_exp        r_s11_eb, r_s11_d;
    logic        r_s11_sb, r_s11_ss, r_s11_az;

    logic [63:0] r_s12_big, r_s12_sml;
    t_exp        r_s12_eb;
    logic        r_s12_sb, r_s12_sub;

    logic [63:0] r_s13_m, r_s14_m;
    t_exp        r_s13_eb, r_s14_eb;
    logic        r_s13_sb, r_s14_sb, r_s15_sb;
    logic        r_s13_cz, r_s14_cz, r_s15_cz;
    logic [5:0]  r_s14_k;
    t_shr        r_s15_shr;

    logic [31:0] r_s16_r;

    assign o_a_updated = r_s16_r;

    // ------------------------------------------------------------------
    // stage 9 decode: unify the product operand and settle special cases
    // ------------------------------------------------------------------
    logic        n_cn, n_ci, n_cz, n_cs;
    logic [47:0] n_cm;
    t_exp        n_ce;
    logic [31:0] n_a;
    logic        n_an, n_ai, n_az, n_sa;
    t_side       n_sd;

    always_comb begin
        if (r_car[8].split) begin
            // product was rounded to binary32 first
            n_cn = f_is_nan(r_s8_p);
            n_ci = f_is_inf(r_s8_p);
            n_cz = f_is_zero(r_s8_p);
            n_cs = r_s8_p[31];
            n_cm = {24'd0, f_unp_m(r_s8_p)};
            n_ce = f_unp_e(r_s8_p);
        end else begin
            n_cn = r_s8_nan;
            n_ci = r_s8_inf;
            n_cz = r_s8_zer;
            n_cs = r_s8_sgn;
            n_cm = r_s8_mp;
            n_ce = r_s8_ep;
        end
        n_a  = r_car[8].a;
        n_an = f_is_nan(n_a);
        n_ai = f_is_inf(n_a);
        n_az = f_is_zero(n_a);
        n_sa = n_a[31];

        n_sd.spec = 1'b1;
        if (r_car[8].byp) begin
            n_sd.val = n_a;
        end else if (n_cn || n_an) begin
            n_sd.val = QNAN_BITS;
        end else if (n_ci) begin
            // infinities of opposite sign are invalid
            n_sd.val = (n_ai && (n_sa != n_cs)) ? QNAN_BITS : {n_cs, INF_MAG};
        end else if (n_ai) begin
            n_sd.val = n_a;
        end else if (n_cz) begin
            if (!n_az) begin
                n_sd.val = n_a;
            end else begin
                n_sd.val = (n_cs == n_sa) ? {n_cs, 31'd0} : 32'd0;
            end
        end else begin
            n_sd.spec = 1'b0;
            n_sd.val  = 32'd0;
        end
    end

    // ------------------------------------------------------------------
    // stage registers
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        // 1: alpha * y mantissa product
        if (en[1]) begin
            r_s1_mp  <= 48'(f_unp_m(r_alpha)) * 48'(f_unp_m(i_y_value));
            r_s1_ep  <= f_unp_e(r_alpha) + f_unp_e(i_y_value);
            r_s1_nan <= f_is_nan(r_alpha) || f_is_nan(i_y_value);
            r_s1_inf <= f_is_inf(r_alpha) || f_is_inf(i_y_value);
            r_s1_sgn <= r_alpha[31] ^ i_y_value[31];
            r_s1_x   <= i_x_value;
            r_car[1] <= '{byp:   f_is_zero(r_alpha) || f_is_zero(i_y_value),
                           split: r_split,
                           a:     i_a_value};
        end
        // 2: leading one
        if (en[2]) begin
            r_s2_k   <= f_msb({16'd0, r_s1_mp});
            r_s2_mp  <= r_s1_mp;
            r_s2_ep  <= r_s1_ep;
            r_s2_nan <= r_s1_nan;
            r_s2_inf <= r_s1_inf;
            r_s2_sgn <= r_s1_sgn;
            r_s2_x   <= r_s1_x;
            r_car[2] <= r_car[1];
        end
        // 3: align
        if (en[3]) begin
            r_s3_shr <= f_align({16'd0, r_s2_mp}, r_s2_ep, r_s2_k);
            r_s3_nan <= r_s2_nan;
            r_s3_inf <= r_s2_inf;
            r_s3_sgn <= r_s2_sgn;
            r_s3_x   <= r_s2_x;
            r_car[3] <= r_car[2];
        end
        // 4: round temp
        if (en[4]) begin
            if (r_s3_nan) begin
                r_s4_t <= QNAN_BITS;
            end else if (r_s3_inf) begin
                r_s4_t <= {r_s3_sgn, INF_MAG};
            end else begin
                r_s4_t <= f_pack(r_s3_sgn, r_s3_shr);
            end
            r_s4_x   <= r_s3_x;
            r_car[4] <= r_car[3];
        end
        // 5: x * temp mantissa product and its class
        if (en[5]) begin
            r_s5_mp  <= 48'(f_unp_m(r_s4_t)) * 48'(f_unp_m(r_s4_x));
            r_s5_ep  <= f_unp_e(r_s4_t) + f_unp_e(r_s4_x);
            r_s5_nan <= f_is_nan(r_s4_t) || f_is_nan(r_s4_x)
                     || ((f_is_inf(r_s4_t) || f_is_inf(r_s4_x))
                         && (f_is_zero(r_s4_t) || f_is_zero(r_s4_x)));
            r_s5_inf <= f_is_inf(r_s4_t) || f_is_inf(r_s4_x);
            r_s5_zer <= f_is_zero(r_s4_t) || f_is_zero(r_s4_x);
            r_s5_sgn <= r_s4_t[31] ^ r_s4_x[31];
            r_car[5] <= r_car[4];
        end
        // 6: leading one
        if (en[6]) begin
            r_s6_k   <= f_msb({16'd0, r_s5_mp});
            r_s6_mp  <= r_s5_mp;
            r_s6_ep  <= r_s5_ep;
            r_s6_nan <= r_s5_nan;
            r_s6_inf <= r_s5_inf;
            r_s6_zer <= r_s5_zer;
            r_s6_sgn <= r_s5_sgn;
            r_car[6] <= r_car[5];
        end
        // 7: align
        if (en[7]) begin
            r_s7_shr <= f_align({16'd0, r_s6_mp}, r_s6_ep, r_s6_k);
            r_s7_mp  <= r_s6_mp;
            r_s7_ep  <= r_s6_ep;
            r_s7_nan <= r_s6_nan;
            r_s7_inf <= r_s6_inf;
            r_s7_zer <= r_s6_zer;
            r_s7_sgn <= r_s6_sgn;
            r_car[7] <= r_car[6];
        end
        // 8: rounded product for split mode
        if (en[8]) begin
            if (r_s7_nan) begin
                r_s8_p <= QNAN_BITS;
            end else if (r_s7_inf) begin
                r_s8_p <= {r_s7_sgn, INF_MAG};
            end else if (r_s7_zer) begin
                r_s8_p <= {r_s7_sgn, 31'd0};
            end else begin
                r_s8_p <= f_pack(r_s7_sgn, r_s7_shr);
            end
            r_s8_mp  <= r_s7_mp;
            r_s8_ep  <= r_s7_ep;
            r_s8_nan <= r_s7_nan;
            r_s8_inf <= r_s7_inf;
            r_s8_zer <= r_s7_zer;
            r_s8_sgn <= r_s7_sgn;
            r_car[8] <= r_car[7];
        end
        // 9: operand select, specials, leading ones
        if (en[9]) begin
            r_sd[9]  <= n_sd;
            r_s9_mp  <= n_cm;
            r_s9_ep  <= n_ce;
            r_s9_sp  <= n_cs;
            r_s9_mc  <= f_unp_m(n_a);
            r_s9_ec  <= f_unp_e(n_a);
            r_s9_sa  <= n_sa;
            r_s9_az  <= n_az;
            r_s9_kp  <= f_msb({16'd0, n_cm});
            r_s9_kc  <= f_msb({40'd0, f_unp_m(n_a)});
        end
        // 10: normalize both to bit 61
        if (en[10]) begin
            r_s10_np <= {16'd0, r_s9_mp} << (6'd61 - r_s9_kp);
            r_s10_ep <= r_s9_ep - t_exp'({6'd0, 6'd61 - r_s9_kp});
            r_s10_nc <= {40'd0, r_s9_mc} << (6'd61 - r_s9_kc);
            r_s10_ec <= r_s9_ec - t_exp'({6'd0, 6'd61 - r_s9_kc});
            r_s10_sp <= r_s9_sp;
            r_s10_sa <= r_s9_sa;
            r_s10_az <= r_s9_az;
            r_sd[10] <= r_sd[9];
        end
        // 11: order by magnitude; a zero addend leaves the product alone
        if (en[11]) begin
            if (r_s10_az || (r_s10_ep > r_s10_ec)
                || ((r_s10_ep == r_s10_ec) && (r_s10_np >= r_s10_nc))) begin
                r_s11_big <= r_s10_np;
                r_s11_eb  <= r_s10_ep;
                r_s11_sb  <= r_s10_sp;
                r_s11_sml <= r_s10_nc;
                r_s11_ss  <= r_s10_sa;
                r_s11_d   <= r_s10_ep - r_s10_ec;
            end else begin
                r_s11_big <= r_s10_nc;
                r_s11_eb  <= r_s10_ec;
                r_s11_sb  <= r_s10_sa;
                r_s11_sml <= r_s10_np;
                r_s11_ss  <= r_s10_sp;
                r_s11_d   <= r_s10_ec - r_s10_ep;
            end
            r_s11_az <= r_s10_az;
            r_sd[11] <= r_sd[10];
        end
        // 12: shift the smaller one right, jamming lost bits into bit 0
        if (en[12]) begin
            if (r_s11_az) begin
                r_s12_sml <= 64'd0;
            end else if (r_s11_d >= t_exp'(62)) begin
                r_s12_sml <= 64'd1;
            end else if (r_s11_d > t_exp'(0)) begin
                r_s12_sml <= (r_s11_sml >> r_s11_d[5:0])
                           | 64'((r_s11_sml & ((64'd1 << r_s11_d[5:0]) - 64'd1)) != 64'd0);
            end else begin
                r_s12_sml <= r_s11_sml;
            end
            r_s12_big <= r_s11_big;
            r_s12_eb  <= r_s11_eb;
            r_s12_sb  <= r_s11_sb;
            r_s12_sub <= (r_s11_sb != r_s11_ss) && !r_s11_az;
            r_sd[12]  <= r_sd[11];
        end
        // 13: add or subtract; exact cancellation gives +0
        if (en[13]) begin
            if (r_s12_sub) begin
                r_s13_m  <= r_s12_big - r_s12_sml;
                r_s13_cz <= r_s12_big == r_s12_sml;
            end else begin
                r_s13_m  <= r_s12_big + r_s12_sml;
                r_s13_cz <= 1'b0;
            end
            r_s13_eb <= r_s12_eb;
            r_s13_sb <= r_s12_sb;
            r_sd[13] <= r_sd[12];
        end
        // 14: leading one
        if (en[14]) begin
            r_s14_k  <= f_msb(r_s13_m);
            r_s14_m  <= r_s13_m;
            r_s14_eb <= r_s13_eb;
            r_s14_sb <= r_s13_sb;
            r_s14_cz <= r_s13_cz;
            r_sd[14] <= r_sd[13];
        end
        // 15: align
        if (en[15]) begin
            r_s15_shr <= f_align(r_s14_m, r_s14_eb, r_s14_k);
            r_s15_sb  <= r_s14_sb;
            r_s15_cz  <= r_s14_cz;
            r_sd[15]  <= r_sd[14];
        end
        // 16: round and select the result
        if (en[16]) begin
            if (r_sd[15].spec) begin
                r_s16_r <= r_sd[15].val;
            end else if (r_s15_cz) begin
                r_s16_r <= 32'd0;
            end else begin
                r_s16_r <= f_pack(r_s15_sb, r_s15_shr);
            end
        end
    end

    // ------------------------------------------------------------------
    // checks
    // ------------------------------------------------------------------
`ifndef SYNTHESIS
    // input backs up only when every stage is full and the output is held
    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> ((&r_vld) && i_stall))
        else $error("input stalled with a free stage");

    // both addends normalized to bit 61 unless the addend is zero
    a_norm: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld[10] && !r_sd[10].spec) |-> (r_s10_np[61] && (r_s10_az || r_s10_nc[61])))
        else $error("adder operands not normalized");

    // the sum never reaches bit 63
    a_sum_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld[13] && !r_sd[13].spec) |-> !r_s13_m[63])
        else $error("adder sum out of range");
`endif

endmodule

`default_nettype wire

// ===== tb/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for rank_one_update_element_top: streams (x, y, a)
// binary32 triples, predicts a + (alpha*y)*x bit for bit in fused and split
// rounding and compares every result item in order.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;
    import rou_pkg::*;

    localparam int          LIMIT_CYCLES = 400000;
    localparam int          DRAIN_CYCLES = 24;    // a bit more than the 16-stage pipe
    localparam logic [31:0] NEG_ZERO     = 32'h8000_0000;
    localparam logic [31:0] FP_ONE       = 32'h3F80_0000;
    localparam logic [30:0] INF_BITS     = 31'h7F80_0000;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_valid;
    logic                 o_stall;
    logic [31:0]          i_x_value;
    logic [31:0]          i_y_value;
    logic [31:0]          i_a_value;
    logic                 o_valid;
    logic                 i_stall;
    logic [31:0]          o_a_updated;
    logic                 i_cfg_valid;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [31:0]          i_cfg_data;

    // bench copy of the configuration
    logic [31:0] alpha_reg;
    logic        split_reg;

    logic [31:0] pending_updates[$];  // expected a_updated, oldest first
    int          mismatches;
    int          cycles;
    int          hold_cycles;         // long receiver hold-off request
    bit          burst;               // sender offers items back to back

    rank_one_update_element_top DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_x_value   (i_x_value),
        .i_y_value   (i_y_value),
        .i_a_value   (i_a_value),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_a_updated (o_a_updated),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    // ------------------------------------------------------------------
    // binary32 arithmetic on bit patterns
    // ------------------------------------------------------------------
    function automatic logic is_nan32(input logic [31:0] v);
        return (v[30:23] == 8'hFF) && (v[22:0] != 23'd0);
    endfunction

    function automatic logic is_inf32(input logic [31:0] v);
        return v[30:0] == INF_BITS;
    endfunction

    function automatic logic is_zero32(input logic [31:0] v);
        return v[30:0] == 31'd0;
    endfunction

    // finite nonzero value = m * 2^e
    function automatic void unpack32(input logic [31:0] v, output logic [63:0] m,
                                     output int e);
        if (v[30:23] == 8'd0) begin
            m = {41'd0, v[22:0]};
            e = -149;
        end else begin
            m = {40'd0, 1'b1, v[22:0]};
            e = int'(v[30:23]) - 150;
        end
    endfunction

    // round nonzero m * 2^e to nearest even, subnormals kept
    function automatic logic [31:0] round32(input logic s, input logic [63:0] m,
                                            input int e);
        int          k;
        int          lsb;
        int          sh;
        logic [63:0] q;
        logic [63:0] rem;
        logic [63:0] half;
        k = 62;
        while (k > 0 && !m[k]) k--;
        lsb = k + e - 23;
        if (lsb < -149) lsb = -149;
        sh = lsb - e;
        if (sh <= 0) begin
            q = m << (-sh);
        end else if (sh >= 64) begin
            q = 64'd0;
        end else begin
            rem  = m & ((64'd1 << sh) - 64'd1);
            half = 64'd1 << (sh - 1);
            q    = m >> sh;
            if (rem > half || (rem == half && q[0])) q++;
        end
        if (q >= (64'd1 << 24)) begin
            q = q >> 1;
            lsb++;
        end
        if (q >= (64'd1 << 23)) begin
            if (lsb + 150 >= 255) return {s, INF_BITS};
            return {s, 8'(lsb + 150), q[22:0]};
        end
        return {s, q[30:0]};
    endfunction

    // round(a*b + c) once; NaNs come out canonical
    function automatic logic [31:0] mul_add32(input logic [31:0] a, input logic [31:0] b,
                                              input logic [31:0] c);
        logic        sp;
        logic        sc;
        logic        sbig;
        logic        ssml;
        logic [63:0] ma;
        logic [63:0] mb;
        logic [63:0] mp;
        logic [63:0] mc;
        logic [63:0] big;
        logic [63:0] sml;
        logic [63:0] sum;
        int          ea;
        int          eb;
        int          ep;
        int          ec;
        int          ebig;
        int          d;
        sp = a[31] ^ b[31];
        sc = c[31];
        if (is_nan32(a) || is_nan32(b) || is_nan32(c)) return QNAN_BITS;
        if (is_inf32(a) || is_inf32(b)) begin
            if (is_zero32(a) || is_zero32(b)) return QNAN_BITS;
            if (is_inf32(c) && sc != sp) return QNAN_BITS;
            return {sp, INF_BITS};
        end
        if (is_inf32(c)) return c;
        if (is_zero32(a) || is_zero32(b)) begin
            if (!is_zero32(c)) return c;
            return (sp == sc) ? {sp, 31'd0} : 32'd0;
        end
        unpack32(a, ma, ea);
        unpack32(b, mb, eb);
        mp = ma * mb;
        ep = ea + eb;
        if (is_zero32(c)) return round32(sp, mp, ep);
        unpack32(c, mc, ec);
        while (!mp[61]) begin
            mp = mp << 1;
            ep--;
        end
        while (!mc[61]) begin
            mc = mc << 1;
            ec--;
        end
        if (ep > ec || (ep == ec && mp >= mc)) begin
            big = mp; ebig = ep; sbig = sp; sml = mc; ssml = sc; d = ep - ec;
        end else begin
            big = mc; ebig = ec; sbig = sc; sml = mp; ssml = sp; d = ec - ep;
        end
        // shifted-out bits fold into a sticky lsb
        if (d >= 62) begin
            sml = 64'd1;
        end else if (d > 0) begin
            sml = (sml >> d) | 64'((sml & ((64'd1 << d) - 64'd1)) != 64'd0);
        end
        if (sbig == ssml) begin
            sum = big + sml;
        end else begin
            sum = big - sml;
            if (sum == 64'd0) return 32'd0;   // exact cancellation is +0
        end
        return round32(sbig, sum, ebig);
    endfunction

    function automatic logic [31:0] predict_update(input logic [31:0] x,
                                                   input logic [31:0] y,
                                                   input logic [31:0] a);
        logic [31:0] scaled;
        if (is_zero32(alpha_reg) || is_zero32(y)) return a;
        scaled = mul_add32(alpha_reg, y, NEG_ZERO);
        if (split_reg) return mul_add32(mul_add32(x, scaled, NEG_ZERO), FP_ONE, a);
        return mul_add32(scaled, x, a);
    endfunction

    // ------------------------------------------------------------------
    // clock, cycle limit, receiver
    // ------------------------------------------------------------------
    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT_CYCLES) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // result checker: one result per accepted item, in order
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_updates.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result %h", o_a_updated);
            end else if (pending_updates[0] !== o_a_updated) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("a_updated mismatch: expected %h, got %h",
                             pending_updates[0], o_a_updated);
                void'(pending_updates.pop_front());
            end else begin
                void'(pending_updates.pop_front());
            end
        end
    end

    // receiver stalls: quiet stretches, short bursts, rare long ones,
    // and the long hold-off when a test asks for it
    initial begin : stall_gen
        int stall_left;
        int quiet_left;
        int r;
        stall_left = 0;
        quiet_left = 0;
        forever begin
            @(posedge i_clk);
            if (hold_cycles > 0) begin
                i_stall <= 1'b1;
                hold_cycles--;
            end else if (stall_left > 0) begin
                i_stall <= 1'b1;
                stall_left--;
            end else if (quiet_left > 0) begin
                i_stall <= 1'b0;
                quiet_left--;
            end else begin
                r = $urandom_range(0, 99);
                i_stall <= 1'b0;
                if (r < 4)
                    quiet_left = $urandom_range(20, 120);
                else if (r < 20)
                    stall_left = $urandom_range(1, 3);
                else if (r < 23)
                    stall_left = $urandom_range(8, 30);
            end
        end
    end

    // ------------------------------------------------------------------
    // sender side
    // ------------------------------------------------------------------
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (burst || r < 72) return 0;
        if (r < 94) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // called at a rising edge; valid stays high when no gap follows
    task automatic send_item(input logic [31:0] x, input logic [31:0] y,
                             input logic [31:0] a);
        int gap;
        i_valid   <= 1'b1;
        i_x_value <= x;
        i_y_value <= y;
        i_a_value <= a;
        do @(posedge i_clk); while (o_stall);
        pending_updates.push_back(predict_update(x, y, a));
        gap = pick_gap();
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // wait for every result, then let the pipe settle
    task automatic drain();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_updates.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_reg idx, input logic [31:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        if (idx == REG_ALPHA) alpha_reg = data;
        else split_reg = data[0];
        @(posedge i_clk);
    endtask

    task automatic set_mode(input logic [31:0] alpha, input logic split);
        drain();
        write_reg(REG_ALPHA, alpha);
        write_reg(REG_SPLIT, {31'd0, split});
    endtask

    // random patterns, a narrow exponent band, subnormals, extreme exponents and specials
    function automatic logic [31:0] pick_operand();
        logic [31:0] specials[10] = '{32'h0000_0000, 32'h8000_0000, 32'h7F80_0000,
                                     32'hFF80_0000, 32'h7FC0_0000, 32'h7F7F_FFFF,
                                     32'h0080_0000, 32'h0000_0001, 32'h3F80_0000,
                                     32'hFFFF_FFFF};
        case ($urandom_range(0, 9))
            0, 1, 2: return $urandom;
            3, 4, 5: return {1'($urandom), 8'($urandom_range(112, 142)), 23'($urandom)};
            6:       return {1'($urandom), 8'd0, 23'($urandom)};
            7:       return {1'($urandom), 8'($urandom_range(1, 20)), 23'($urandom)};
            8:       return {1'($urandom), 8'($urandom_range(236, 254)), 23'($urandom)};
            default: return specials[$urandom_range(0, 9)];
        endcase
    endfunction

    task automatic send_random_item();
        logic [31:0] x;
        logic [31:0] y;
        logic [31:0] a;
        x = pick_operand();
        y = pick_operand();
        a = pick_operand();
        // near-cancellation: a close to minus the product
        if ($urandom_range(0, 4) == 0 && !is_zero32(alpha_reg)) begin
            a = mul_add32(mul_add32(alpha_reg, y, NEG_ZERO), x, NEG_ZERO);
            a = {~a[31], a[30:2], a[1:0] ^ 2'($urandom)};
        end
        send_item(x, y, a);
    endtask

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------
    task automatic test_reset_state();
        // alpha resets to zero: a passes through, NaN too
        send_item(32'h3F80_0000, 32'h3F80_0000, 32'h7FC1_2345);
        send_item(32'h4000_0000, 32'h4040_0000, 32'hC120_0000);
    endtask

    task automatic test_special_cases();
        set_mode(FP_ONE, 1'b0);
        send_item(32'h3F80_0000, 32'h3F80_0000, 32'h3F80_0000);  // 1 + 1
        send_item(32'h3F80_0000, 32'h0000_0000, 32'h7FA0_0001);  // zero y, NaN a kept
        send_item(32'h7F80_0000, 32'h8000_0000, 32'hFF80_0000);  // -0 y, a kept
        send_item(32'h7FA0_0000, 32'h3F80_0000, 32'h3F80_0000);  // NaN x
        send_item(32'h3F80_0000, 32'h3F80_0000, 32'hFFC0_0001);  // NaN a
        send_item(32'h7F80_0000, 32'h3F80_0000, 32'hFF80_0000);  // inf - inf
        send_item(32'h7F80_0000, 32'h3F80_0000, 32'h3F80_0000);  // inf
        send_item(32'h0000_0000, 32'h7F80_0000, 32'h3F80_0000);  // 0 * inf
        send_item(32'h3F80_0000, 32'h3F80_0000, 32'hBF80_0000);  // exact cancel, +0
        send_item(32'h8000_0000, 32'h3F80_0000, 32'h8000_0000);  // -0 + -0
        send_item(32'h7F7F_FFFF, 32'h4000_0000, 32'h0000_0000);  // overflow
        send_item(32'h0000_0001, 32'h3F00_0000, 32'h0000_0000);  // underflow tie
        send_item(32'h0000_0003, 32'h3F00_0000, 32'h8000_0000);  // underflow round up
        send_item(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);  // all ones
        send_item(32'h0000_0000, 32'h0000_0000, 32'h0000_0000);  // all zeros
        set_mode(32'h3F80_0001, 1'b1);                           // split rounding
        send_item(32'h3F80_0001, 32'h3F80_0001, 32'hBF80_0002);
        send_item(32'h0080_0001, 32'h3F00_0001, 32'h8080_0000);
        send_item(32'h7F80_0000, 32'h3F80_0000, 32'h7F80_0000);
        set_mode(32'hFFFF_FFFF, 1'b1);                           // NaN alpha
        send_item(32'h3F80_0000, 32'h3F80_0000, 32'h3F80_0000);
        set_mode(32'h7F7F_FFFF, 1'b0);                           // big alpha
        send_item(32'h3F80_0000, 32'h4000_0000, 32'hFF7F_FFFF);
    endtask

    task automatic test_random_streams();
        logic [31:0] alphas[8] = '{32'h3F80_0000, 32'h0000_0000, 32'h7F7F_FFFF,
                                  32'h0000_0001, 32'hFFFF_FFFF, 32'h8080_0000,
                                  32'hBE99_999A, 32'h7F80_0000};
        logic [31:0] alpha;
        for (int phase = 0; phase < 12; phase++) begin
            alpha = (phase < 8) ? alphas[phase] : pick_operand();
            if (phase >= 8 && is_zero32(alpha)) alpha = 32'h4049_0FDB;
            set_mode(alpha, phase[0]);
            repeat (110) send_random_item();
        end
    endtask

    // receiver holds off while the sender keeps offering: pipe fills up
    task automatic test_backpressure();
        set_mode(32'h3FC0_0000, 1'b0);
        hold_cycles = 120;
        burst       = 1'b1;
        repeat (70) send_random_item();
        burst = 1'b0;
        set_mode(32'hC0A0_0000, 1'b1);
        hold_cycles = 60;
        repeat (40) send_random_item();
    endtask

    initial begin
        i_rst_n     = 1'b0;
        i_valid     = 1'b0;
        i_x_value   = 32'd0;
        i_y_value   = 32'd0;
        i_a_value   = 32'd0;
        i_stall     = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_index = REG_ALPHA;
        i_cfg_data  = 32'd0;
        alpha_reg   = 32'd0;
        split_reg   = 1'b0;
        mismatches  = 0;
        cycles      = 0;
        hold_cycles = 0;
        burst       = 1'b0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_state();
        test_special_cases();
        test_random_streams();
        test_backpressure();
        drain();

        if (mismatches == 0 && pending_updates.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

`default_nettype wire
